// ===== rtl/icaf_pkg.sv =====
// Package for the IMU complementary attitude filter.
// Holds the fixed-point constants, register codes, shared types and helper functions.
// No dependencies.
package icaf_pkg;

  localparam int CORDIC_STEPS    = 16;
  localparam int ANGLE_FRAC_BITS = 16;

  localparam int IDX_W       = $clog2(CORDIC_STEPS);
  localparam int ANGLE_SHIFT = 32 - ANGLE_FRAC_BITS;
  localparam int BLEND_SHIFT = 16;
  localparam int PRESCALE_SH = 16;

  // CORDIC datapath widths: x grows by the CORDIC gain, z holds Q.32 degrees.
  localparam int XY_W   = 36;
  localparam int Z_W    = 44;
  localparam int ACC_W  = ANGLE_FRAC_BITS + 10;
  localparam int PROD_W = 50;
  localparam int STEP_W = ANGLE_FRAC_BITS + 18;
  localparam int DIFF_W = ((STEP_W > 32) ? STEP_W : 32) + 1;
  localparam int BM_W   = DIFF_W + 17;
  localparam int AM_W   = ACC_W + 18;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [63:0] DEG_PER_RAD_Q32 = 64'd246083499207;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_OFFSET_X = 3'd0,
    REG_OFFSET_Y = 3'd1,
    REG_OFFSET_Z = 3'd2,
    REG_STEP_GAIN = 3'd3,
    REG_BLEND_WEIGHT = 3'd4
  } cfg_reg_e;

  typedef struct packed {
    logic signed [15:0] offset_x;
    logic signed [15:0] offset_y;
    logic signed [15:0] offset_z;
    logic [31:0]        step_gain;
    logic [15:0]        weight;
  } cfg_t;

  typedef struct packed {
    logic load;
    logic gmul;
    logic gdif;
    logic bmul;
    logic commit;
  } merge_ctl_t;

  // Division by the odd constant 2k+1, used only to build the arctangent table.
  function automatic logic [63:0] odd_div(input logic [63:0] v, input int k);
    case (k)
      0: odd_div = v;
      1: odd_div = v / 3;
      2: odd_div = v / 5;
      3: odd_div = v / 7;
      4: odd_div = v / 9;
      5: odd_div = v / 11;
      6: odd_div = v / 13;
      7: odd_div = v / 15;
      8: odd_div = v / 17;
      9: odd_div = v / 19;
      10: odd_div = v / 21;
      11: odd_div = v / 23;
      12: odd_div = v / 25;
      13: odd_div = v / 27;
      14: odd_div = v / 29;
      15: odd_div = v / 31;
      16: odd_div = v / 33;
      17: odd_div = v / 35;
      18: odd_div = v / 37;
      19: odd_div = v / 39;
      20: odd_div = v / 41;
      21: odd_div = v / 43;
      22: odd_div = v / 45;
      23: odd_div = v / 47;
      24: odd_div = v / 49;
      25: odd_div = v / 51;
      26: odd_div = v / 53;
      27: odd_div = v / 55;
      28: odd_div = v / 57;
      29: odd_div = v / 59;
      30: odd_div = v / 61;
      31: odd_div = v / 63;
      default: odd_div = 64'd0;
    endcase
  endfunction

  // atan(2^-i) in Q.32 degrees from its series, carried with 20 guard bits.
  function automatic logic [63:0] cordic_angle(input int i);
    logic [63:0] kx;
    logic [63:0] sum;
    logic [63:0] term;
    int n;
    kx  = DEG_PER_RAD_Q32 << 20;
    sum = 64'd0;
    if (i == 0) begin
      return 64'd45 << 32;
    end
    for (int k = 0; k < 32; k++) begin
      n = i * (2 * k + 1);
      if (n < 64) begin
        term = odd_div(kx >> n, k);
        if (k % 2 == 1) begin
          sum = sum - term;
        end else begin
          sum = sum + term;
        end
      end
    end
    return (sum + (64'd1 << 19)) >> 20;
  endfunction

  // Divide by 2^s, rounding to nearest with ties away from zero.
  function automatic logic signed [63:0] round_shift(input logic signed [63:0] v,
                                                     input int s);
    logic signed [63:0] half;
    half = 64'sd1 <<< (s - 1);
    if (s == 0) begin
      return v;
    end
    if (!v[63]) begin
      return (v + half) >>> s;
    end
    return -((-v + half) >>> s);
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) begin
      return 32'sh7fffffff;
    end
    if (v < -64'sd2147483648) begin
      return 32'sh80000000;
    end
    return v[31:0];
  endfunction

endpackage

// ===== rtl/icaf_if.sv =====
// Valid/ready channel interfaces for the IMU attitude filter: one raw sample in,
// one set of angles out. No dependencies.
interface icaf_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] accel_x;
  logic signed [15:0] accel_y;
  logic signed [15:0] accel_z;
  logic signed [15:0] rate_x;
  logic signed [15:0] rate_y;
  logic signed [15:0] rate_z;

  modport source (output valid, accel_x, accel_y, accel_z, rate_x, rate_y, rate_z,
                  input ready);
  modport sink (input valid, accel_x, accel_y, accel_z, rate_x, rate_y, rate_z,
                output ready);
endinterface

interface icaf_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] roll_deg;
  logic signed [31:0] pitch_deg;
  logic signed [31:0] yaw_deg;

  modport source (output valid, roll_deg, pitch_deg, yaw_deg, input ready);
  modport sink (input valid, roll_deg, pitch_deg, yaw_deg, output ready);
endinterface

// ===== rtl/icaf_lane.sv =====
// One CORDIC lane: atan2(num, den) in degrees, one vectoring step per cycle.
// Depends on icaf_pkg.
module icaf_lane (
  input  logic                               clk,
  input  logic                               load,
  input  logic signed [15:0]                 num,
  input  logic signed [15:0]                 den,
  input  logic                               iter,
  input  logic [icaf_pkg::IDX_W-1:0]         idx,
  output logic signed [icaf_pkg::ACC_W-1:0]  angle
);

  logic signed [icaf_pkg::XY_W-1:0] x;
  logic signed [icaf_pkg::XY_W-1:0] y;
  logic signed [icaf_pkg::Z_W-1:0]  z;
  logic                             zero;
  logic signed [icaf_pkg::XY_W-1:0] num_e;
  logic signed [icaf_pkg::XY_W-1:0] den_e;
  logic signed [icaf_pkg::XY_W-1:0] dx;
  logic signed [icaf_pkg::XY_W-1:0] dy;
  logic signed [icaf_pkg::Z_W-1:0]  tab [icaf_pkg::CORDIC_STEPS];
  logic signed [63:0]               z_rnd;

  for (genvar g = 0; g < icaf_pkg::CORDIC_STEPS; g++) begin : g_tab
    assign tab[g] = icaf_pkg::Z_W'(icaf_pkg::cordic_angle(g));
  end

  assign num_e = icaf_pkg::XY_W'(num);
  assign den_e = icaf_pkg::XY_W'(den);
  assign dx    = y >>> idx;
  assign dy    = x >>> idx;

  always_ff @(posedge clk) begin
    if (load) begin
      zero <= (num == 16'sd0) && (den == 16'sd0);
      if (den < 16'sd0) begin
        // Left half plane: turn the vector by 180 degrees first.
        z <= (num >= 16'sd0) ? (icaf_pkg::Z_W'(180) <<< 32) : -(icaf_pkg::Z_W'(180) <<< 32);
        x <= (-den_e) <<< icaf_pkg::PRESCALE_SH;
        y <= (-num_e) <<< icaf_pkg::PRESCALE_SH;
      end else begin
        z <= '0;
        x <= den_e <<< icaf_pkg::PRESCALE_SH;
        y <= num_e <<< icaf_pkg::PRESCALE_SH;
      end
    end else if (iter) begin
      if (!y[icaf_pkg::XY_W-1]) begin
        x <= x + dx;
        y <= y - dy;
        z <= z + tab[idx];
      end else begin
        x <= x - dx;
        y <= y + dy;
        z <= z - tab[idx];
      end
    end
  end

  assign z_rnd = icaf_pkg::round_shift(64'(z), icaf_pkg::ANGLE_SHIFT);
  assign angle = zero ? '0 : icaf_pkg::ACC_W'(z_rnd);

endmodule

// ===== rtl/icaf_merge.sv =====
// Merging stage: gyro angle steps, complementary blend of the two lane angles,
// yaw integration and the angle state. Depends on icaf_pkg.
module icaf_merge (
  input  logic                              clk,
  input  logic                              rst,
  input  icaf_pkg::merge_ctl_t              ctl,
  input  icaf_pkg::cfg_t                    cfg,
  input  logic signed [15:0]                rate_x,
  input  logic signed [15:0]                rate_y,
  input  logic signed [15:0]                rate_z,
  input  logic signed [icaf_pkg::ACC_W-1:0] acc_roll,
  input  logic signed [icaf_pkg::ACC_W-1:0] acc_pitch,
  output logic signed [31:0]                roll,
  output logic signed [31:0]                pitch,
  output logic signed [31:0]                yaw
);

  logic signed [15:0]                  rx, ry, rz;
  logic signed [icaf_pkg::PROD_W-1:0]  px, py, pz;
  logic signed [icaf_pkg::DIFF_W-1:0]  droll, dpitch;
  logic signed [icaf_pkg::ACC_W-1:0]   aroll, apitch;
  logic signed [31:0]                  yaw_next;
  logic signed [icaf_pkg::BM_W-1:0]    m_roll, m_pitch;
  logic signed [icaf_pkg::AM_W-1:0]    a_roll, a_pitch;
  logic signed [16:0]                  gx, gy, gz;
  logic signed [32:0]                  gain_s;
  logic signed [icaf_pkg::STEP_W-1:0]  sx, sy, sz;
  logic signed [16:0]                  w_s;
  logic signed [17:0]                  wc_s;
  logic signed [63:0]                  sum_roll, sum_pitch;

  assign gx     = 17'(rx) - 17'(cfg.offset_x);
  assign gy     = 17'(ry) - 17'(cfg.offset_y);
  assign gz     = 17'(rz) - 17'(cfg.offset_z);
  assign gain_s = $signed({1'b0, cfg.step_gain});
  assign sx     = icaf_pkg::STEP_W'(icaf_pkg::round_shift(64'(px), icaf_pkg::ANGLE_SHIFT));
  assign sy     = icaf_pkg::STEP_W'(icaf_pkg::round_shift(64'(py), icaf_pkg::ANGLE_SHIFT));
  assign sz     = icaf_pkg::STEP_W'(icaf_pkg::round_shift(64'(pz), icaf_pkg::ANGLE_SHIFT));
  assign w_s    = $signed({1'b0, cfg.weight});
  assign wc_s   = $signed(18'd65536 - {2'b00, cfg.weight});
  assign sum_roll  = 64'(m_roll) + 64'(a_roll);
  assign sum_pitch = 64'(m_pitch) + 64'(a_pitch);

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      rx <= rate_x;
      ry <= rate_y;
      rz <= rate_z;
    end
    if (ctl.gmul) begin
      px <= icaf_pkg::PROD_W'(gx * gain_s);
      py <= icaf_pkg::PROD_W'(gy * gain_s);
      pz <= icaf_pkg::PROD_W'(gz * gain_s);
    end
    if (ctl.gdif) begin
      // Gyro y drives roll and gyro x drives pitch.
      droll    <= icaf_pkg::DIFF_W'(roll) - icaf_pkg::DIFF_W'(sy);
      dpitch   <= icaf_pkg::DIFF_W'(pitch) - icaf_pkg::DIFF_W'(sx);
      yaw_next <= icaf_pkg::sat32(64'(yaw) + 64'(sz));
      aroll    <= acc_roll;
      apitch   <= acc_pitch;
    end
    if (ctl.bmul) begin
      m_roll  <= icaf_pkg::BM_W'(w_s * droll);
      m_pitch <= icaf_pkg::BM_W'(w_s * dpitch);
      a_roll  <= icaf_pkg::AM_W'(wc_s * aroll);
      a_pitch <= icaf_pkg::AM_W'(wc_s * apitch);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      roll  <= '0;
      pitch <= '0;
      yaw   <= '0;
    end else if (ctl.commit) begin
      roll  <= icaf_pkg::sat32(icaf_pkg::round_shift(sum_roll, icaf_pkg::BLEND_SHIFT));
      pitch <= icaf_pkg::sat32(icaf_pkg::round_shift(sum_pitch, icaf_pkg::BLEND_SHIFT));
      yaw   <= yaw_next;
    end
  end

endmodule

// ===== rtl/imu_complementary_attitude_filter.sv =====
// Top level of the IMU complementary attitude filter: channels, register port,
// sequencer and assertions. Depends on icaf_pkg, icaf_if, icaf_lane, icaf_merge.
//
// Usage: in_ch carries one raw IMU sample per item (accelerometer and gyro, three
// axes each); out_ch carries one item with roll, pitch and yaw in signed Q16.16
// degrees for every sample taken. The register port (cfg_en, cfg_index, cfg_data)
// writes the gyro offsets, the gyro step gain and the blend weight; write it only
// while no sample is in flight.
// Two CORDIC lanes, one for roll and one for pitch, run side by side, one step
// per cycle for CORDIC_STEPS steps; the merge stage then works in order through
// gyro product, step and difference, blend products, and round and commit.
// The result item is raised in the output register by the commit. in_ch.ready
// is high only while no sample is in work, so a new sample is taken only after
// the last one has been committed. A result waits in the output register while
// out_ch.ready is low; the next sample may be taken and worked meanwhile, and it
// holds before its commit until the waiting item has been taken.
// Reset clears the angle state to zero, loads the register reset values and
// empties the output register.
module imu_complementary_attitude_filter (
  input  logic                              clk,
  input  logic                              rst,
  icaf_in_if.sink                           in_ch,
  icaf_out_if.source                        out_ch,
  input  logic                              cfg_en,
  input  logic [icaf_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [icaf_pkg::CFG_DATA_W-1:0]   cfg_data
);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_RUN  = 6'b000010,
    S_GMUL = 6'b000100,
    S_GDIF = 6'b001000,
    S_BMUL = 6'b010000,
    S_DONE = 6'b100000
  } state_t;

  state_t                            state, state_next;
  logic [icaf_pkg::IDX_W-1:0]        idx;
  logic                              out_valid;
  logic                              accept;
  logic                              out_free;
  icaf_pkg::cfg_t                    cfg;
  icaf_pkg::merge_ctl_t              ctl;
  logic signed [icaf_pkg::ACC_W-1:0] acc_roll, acc_pitch;

  assign accept   = in_ch.valid && in_ch.ready;
  assign out_free = !out_valid || out_ch.ready;
  assign in_ch.ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.offset_x  <= '0;
      cfg.offset_y  <= '0;
      cfg.offset_z  <= '0;
      cfg.step_gain <= 32'd262290;
      cfg.weight    <= 16'd64225;
    end else if (cfg_en) begin
      case (icaf_pkg::cfg_reg_e'(cfg_index))
        icaf_pkg::REG_OFFSET_X:     cfg.offset_x  <= cfg_data[15:0];
        icaf_pkg::REG_OFFSET_Y:     cfg.offset_y  <= cfg_data[15:0];
        icaf_pkg::REG_OFFSET_Z:     cfg.offset_z  <= cfg_data[15:0];
        icaf_pkg::REG_STEP_GAIN:    cfg.step_gain <= cfg_data[31:0];
        icaf_pkg::REG_BLEND_WEIGHT: cfg.weight    <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    state_next = state;
    ctl        = '0;
    ctl.load   = accept;
    case (state)
      S_IDLE: if (accept) state_next = S_RUN;
      S_RUN: begin
        if (idx == icaf_pkg::IDX_W'(icaf_pkg::CORDIC_STEPS - 1)) state_next = S_GMUL;
      end
      S_GMUL: begin
        ctl.gmul   = 1'b1;
        state_next = S_GDIF;
      end
      S_GDIF: begin
        ctl.gdif   = 1'b1;
        state_next = S_BMUL;
      end
      S_BMUL: begin
        ctl.bmul   = 1'b1;
        state_next = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          ctl.commit = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      idx       <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_RUN) begin
        idx <= (idx == icaf_pkg::IDX_W'(icaf_pkg::CORDIC_STEPS - 1)) ? '0 : idx + 1'b1;
      end
      if (ctl.commit) begin
        out_valid <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  icaf_lane u_lane_roll (
    .clk   (clk),
    .load  (accept),
    .num   (in_ch.accel_x),
    .den   (in_ch.accel_z),
    .iter  (state == S_RUN),
    .idx   (idx),
    .angle (acc_roll)
  );

  icaf_lane u_lane_pitch (
    .clk   (clk),
    .load  (accept),
    .num   (in_ch.accel_y),
    .den   (in_ch.accel_z),
    .iter  (state == S_RUN),
    .idx   (idx),
    .angle (acc_pitch)
  );

  icaf_merge u_merge (
    .clk       (clk),
    .rst       (rst),
    .ctl       (ctl),
    .cfg       (cfg),
    .rate_x    (in_ch.rate_x),
    .rate_y    (in_ch.rate_y),
    .rate_z    (in_ch.rate_z),
    .acc_roll  (acc_roll),
    .acc_pitch (acc_pitch),
    .roll      (out_ch.roll_deg),
    .pitch     (out_ch.pitch_deg),
    .yaw       (out_ch.yaw_deg)
  );

  assign out_ch.valid = out_valid;

  a_commit_free: assert property (@(posedge clk) disable iff (rst)
      ctl.commit |-> (!out_valid || out_ch.ready))
    else $error("angle state committed while a result item was still waiting");

  a_accept_runs: assert property (@(posedge clk) disable iff (rst)
      accept |=> (state == S_RUN) && (idx == '0))
    else $error("accepted item did not start the CORDIC lanes at step zero");

  a_valid_from_done: assert property (@(posedge clk) disable iff (rst)
      $rose(out_valid) |-> $past(state == S_DONE))
    else $error("result item raised outside the commit step");

endmodule

// ===== tb/icaf_tb_if.sv =====
`timescale 1ns / 1ps
// Testbench types for the attitude filter; the channel interfaces come from
// rtl/icaf_if.sv. No dependencies.
package icaf_tb_pkg;

  typedef struct packed {
    logic signed [31:0] roll;
    logic signed [31:0] pitch;
    logic signed [31:0] yaw;
  } attitude_t;
endpackage

// ===== tb/icaf_checker.sv =====
`timescale 1ns / 1ps
// Attitude checker: watches the sample and angle channels, predicts each angle set
// from its own copy of the filter state and registers, and counts mismatches.
// Depends on icaf_pkg, icaf_tb_pkg and the channel interfaces.
module icaf_checker (
  input  logic                            clk,
  input  logic                            rst,
  icaf_in_if                              in_ch,
  icaf_out_if                             out_ch,
  input  logic                            cfg_en,
  input  logic [icaf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [icaf_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                              errors,
  output int                              pending
);

  logic signed [15:0]    off_x, off_y, off_z;
  logic [31:0]           gain;
  logic [15:0]           weight;
  logic signed [31:0]    roll_st, pitch_st, yaw_st;
  longint                atan_tab [icaf_pkg::CORDIC_STEPS];
  icaf_tb_pkg::attitude_t expected_angles [$];

  function automatic longint floor_shift(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint near_shift(longint v, int s);
    longint h;
    if (s == 0) begin
      return v;
    end
    h = 64'sd1 <<< (s - 1);
    if (v >= 0) begin
      return (v + h) >>> s;
    end
    return -((-v + h) >>> s);
  endfunction

  function automatic logic signed [31:0] clamp32(longint v);
    if (v > 64'sd2147483647) begin
      return 32'sh7fffffff;
    end
    if (v < -64'sd2147483648) begin
      return 32'sh80000000;
    end
    return v[31:0];
  endfunction

  // Arctangent of 2^-i in Q.32 degrees, from the odd power series.
  function automatic longint atan_entry(int i);
    logic [63:0] kx, acc, term;
    int k;
    kx  = 64'd246083499207 << 20;
    acc = 0;
    k   = 0;
    if (i == 0) begin
      return longint'(64'd45 << 32);
    end
    while (i * (2 * k + 1) < 64) begin
      term = (kx >> (i * (2 * k + 1))) / (2 * k + 1);
      if (k % 2 == 1) begin
        acc = acc - term;
      end else begin
        acc = acc + term;
      end
      k++;
    end
    return longint'((acc + (64'd1 << 19)) >> 20);
  endfunction

  function automatic longint tilt_angle(longint num, longint den);
    longint x, y, z, dx, dy;
    z = 0;
    if (num == 0 && den == 0) begin
      return 0;
    end
    if (den < 0) begin
      z   = (num >= 0) ? (64'sd180 <<< 32) : -(64'sd180 <<< 32);
      den = -den;
      num = -num;
    end
    x = den * 65536;
    y = num * 65536;
    for (int i = 0; i < icaf_pkg::CORDIC_STEPS; i++) begin
      dx = floor_shift(y, i);
      dy = floor_shift(x, i);
      if (y >= 0) begin
        x += dx; y -= dy; z += atan_tab[i];
      end else begin
        x -= dx; y += dy; z -= atan_tab[i];
      end
    end
    return near_shift(z, 32 - icaf_pkg::ANGLE_FRAC_BITS);
  endfunction

  function automatic longint rate_step(logic signed [15:0] raw, logic signed [15:0] off);
    longint g;
    g = longint'(raw) - longint'(off);
    return near_shift(g * longint'({32'd0, gain}), 32 - icaf_pkg::ANGLE_FRAC_BITS);
  endfunction

  function automatic logic signed [31:0] mix(logic signed [31:0] ang, longint stp,
                                            longint tilt);
    longint w;
    w = longint'({48'd0, weight});
    return clamp32(near_shift(w * (longint'(ang) - stp) + (65536 - w) * tilt, 16));
  endfunction

  task automatic report(string what, logic signed [31:0] got, logic signed [31:0] want);
    $display("MISMATCH %0t %s: got %0d expected %0d", $time, what, got, want);
    errors++;
  endtask

  initial begin
    for (int i = 0; i < icaf_pkg::CORDIC_STEPS; i++) begin
      atan_tab[i] = atan_entry(i);
    end
    errors = 0;
  end

  assign pending = expected_angles.size();

  always @(posedge clk) begin
    icaf_tb_pkg::attitude_t want, got;
    longint sx, sy;
    if (rst) begin
      off_x <= 0; off_y <= 0; off_z <= 0;
      gain <= 32'd262290; weight <= 16'd64225;
      roll_st <= 0; pitch_st <= 0; yaw_st <= 0;
      expected_angles.delete();
    end else begin
      if (cfg_en) begin
        case (cfg_index)
          icaf_pkg::REG_OFFSET_X:     off_x <= cfg_data[15:0];
          icaf_pkg::REG_OFFSET_Y:     off_y <= cfg_data[15:0];
          icaf_pkg::REG_OFFSET_Z:     off_z <= cfg_data[15:0];
          icaf_pkg::REG_STEP_GAIN:    gain <= cfg_data;
          icaf_pkg::REG_BLEND_WEIGHT: weight <= cfg_data[15:0];
          default: ;
        endcase
      end
      if (in_ch.valid && in_ch.ready) begin
        sx = rate_step(in_ch.rate_x, off_x);
        sy = rate_step(in_ch.rate_y, off_y);
        want.roll  = mix(roll_st, sy, tilt_angle(in_ch.accel_x, in_ch.accel_z));
        want.pitch = mix(pitch_st, sx, tilt_angle(in_ch.accel_y, in_ch.accel_z));
        want.yaw   = clamp32(longint'(yaw_st) + rate_step(in_ch.rate_z, off_z));
        roll_st  <= want.roll;
        pitch_st <= want.pitch;
        yaw_st   <= want.yaw;
        expected_angles.push_back(want);
      end
      if (out_ch.valid && out_ch.ready) begin
        got = '{out_ch.roll_deg, out_ch.pitch_deg, out_ch.yaw_deg};
        if (expected_angles.size() == 0) begin
          report("angle item with nothing expected, roll", got.roll, 32'sd0);
        end else begin
          want = expected_angles.pop_front();
          if (got.roll !== want.roll) report("roll", got.roll, want.roll);
          if (got.pitch !== want.pitch) report("pitch", got.pitch, want.pitch);
          if (got.yaw !== want.yaw) report("yaw", got.yaw, want.yaw);
        end
      end
    end
  end
endmodule

// ===== tb/imu_complementary_attitude_filter_tb.sv =====
`timescale 1ns / 1ps
// Top of the attitude filter testbench: clock, reset, register writes, sample
// stimulus with bursty idling and output stalls, and the verdict from icaf_checker.
module imu_complementary_attitude_filter_tb;

  localparam int WATCHDOG_LIMIT = 20000;

  logic                            clk = 0;
  logic                            rst = 1;
  logic                            cfg_en = 0;
  logic [icaf_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [icaf_pkg::CFG_DATA_W-1:0] cfg_data = '0;
  int                              errors, pending;
  int                              idle_cycles = 0;
  int                              stall_mode = 0;
  int                              burst_left = 0;

  icaf_in_if  in_ch ();
  icaf_out_if out_ch ();

  imu_complementary_attitude_filter u_dut (
    .clk(clk), .rst(rst), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_en(cfg_en), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  icaf_checker u_chk (
    .clk(clk), .rst(rst), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_en(cfg_en), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .errors(errors), .pending(pending)
  );

  always #5 clk = ~clk;

  initial begin
    in_ch.valid = 0;
    {in_ch.accel_x, in_ch.accel_y, in_ch.accel_z} = '0;
    {in_ch.rate_x, in_ch.rate_y, in_ch.rate_z} = '0;
    out_ch.ready = 0;
  end

  // The receiver switches between always ready, light stalls and long stalls.
  always @(posedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b0;
    end else begin
      if ($urandom_range(0, 199) == 0) stall_mode = $urandom_range(0, 2);
      case (stall_mode)
        0: out_ch.ready <= 1'b1;
        1: out_ch.ready <= ($urandom_range(0, 3) != 0);
        default: out_ch.ready <= ($urandom_range(0, 9) == 0);
      endcase
    end
  end

  always @(posedge clk) begin
    if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog expired");
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  task automatic write_reg(icaf_pkg::cfg_reg_e idx, logic [31:0] val);
    cfg_en    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_en <= 1'b0;
  endtask

  // Writes an index outside the register list, which must change nothing.
  task automatic write_stray();
    cfg_en    <= 1'b1;
    cfg_index <= 3'd7;
    cfg_data  <= $urandom;
    @(posedge clk);
    cfg_en <= 1'b0;
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    burst_left = 0;
    while (pending != 0) @(posedge clk);
    repeat (icaf_pkg::CORDIC_STEPS + 10) @(posedge clk);
  endtask

  // Presents one sample and holds it until taken; gaps come between bursts.
  // Valid stays high after the accepting edge only when the next item follows
  // in the same time step, so no item is taken twice.
  task automatic send_sample(logic [15:0] ax, logic [15:0] ay, logic [15:0] az,
                             logic [15:0] gx, logic [15:0] gy, logic [15:0] gz);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 30);
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
    in_ch.valid   <= 1'b1;
    in_ch.accel_x <= ax; in_ch.accel_y <= ay; in_ch.accel_z <= az;
    in_ch.rate_x  <= gx; in_ch.rate_y  <= gy; in_ch.rate_z  <= gz;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  function automatic logic [15:0] edge_val();
    case ($urandom_range(0, 5))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'h0000;
      3: return 16'hffff;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic random_phase(int n, int gyro_span);
    logic [15:0] ax, ay, az;
    for (int i = 0; i < n; i++) begin
      ax = 16'($urandom); ay = 16'($urandom); az = 16'($urandom);
      if ($urandom_range(0, 7) == 0) ax = edge_val();
      if ($urandom_range(0, 7) == 0) az = edge_val();
      if ($urandom_range(0, 3) == 0) begin
        send_sample(ax, ay, az, 16'($urandom), 16'($urandom), 16'($urandom));
      end else begin
        send_sample(ax, ay, az, 16'($urandom_range(0, 2 * gyro_span) - gyro_span),
                    16'($urandom_range(0, 2 * gyro_span) - gyro_span),
                    16'($urandom_range(0, 2 * gyro_span) - gyro_span));
      end
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: zero vector, axis cases, sign flips, extremes.
    send_sample(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
    send_sample(16'd1000, 16'hfc18, 16'd0, 16'd0, 16'd0, 16'd0);
    send_sample(16'd0, 16'd0, 16'hc000, 16'd0, 16'd0, 16'd0);
    send_sample(16'd500, 16'hfe0c, 16'hc000, 16'd0, 16'd0, 16'd0);
    send_sample(16'h7fff, 16'h8000, 16'h7fff, 16'h7fff, 16'h8000, 16'h7fff);
    send_sample(16'h8000, 16'h7fff, 16'h8000, 16'h8000, 16'h7fff, 16'h8000);
    send_sample(16'h8000, 16'h8000, 16'd0, 16'hffff, 16'h0001, 16'hffff);
    send_sample(16'h0001, 16'hffff, 16'h0001, 16'd100, 16'hff9c, 16'd3);
    send_sample(16'hffff, 16'h0001, 16'hffff, 16'd0, 16'd0, 16'd0);
    drain();

    // Extremes of every register; large gain and offsets drive yaw into saturation.
    write_reg(icaf_pkg::REG_OFFSET_X, 32'hffff8000);
    write_reg(icaf_pkg::REG_OFFSET_Y, 32'h00007fff);
    write_reg(icaf_pkg::REG_OFFSET_Z, 32'h12348000);
    write_reg(icaf_pkg::REG_STEP_GAIN, 32'hffffffff);
    write_reg(icaf_pkg::REG_BLEND_WEIGHT, 32'hffff_ffff);
    write_stray();
    for (int i = 0; i < 12; i++) send_sample(edge_val(), edge_val(), edge_val(),
                                             16'h7fff, 16'h8000, 16'h7fff);
    for (int i = 0; i < 6; i++) send_sample(edge_val(), edge_val(), edge_val(),
                                            16'h8000, 16'h7fff, 16'h8000);
    drain();

    write_reg(icaf_pkg::REG_BLEND_WEIGHT, 32'h0);
    write_reg(icaf_pkg::REG_STEP_GAIN, 32'h0);
    write_reg(icaf_pkg::REG_OFFSET_Z, 32'h7fff);
    random_phase(20, 32767);
    drain();

    for (int p = 0; p < 5; p++) begin
      write_reg(icaf_pkg::REG_OFFSET_X, $urandom_range(0, 400) - 200);
      write_reg(icaf_pkg::REG_OFFSET_Y, $urandom_range(0, 400) - 200);
      write_reg(icaf_pkg::REG_OFFSET_Z,
                (p == 2) ? $urandom : $urandom_range(0, 400) - 200);
      write_reg(icaf_pkg::REG_STEP_GAIN,
                (p == 3) ? $urandom : $urandom_range(100000, 400000));
      write_reg(icaf_pkg::REG_BLEND_WEIGHT,
                (p == 4) ? 32'd65535 : $urandom_range(40000, 65535));
      random_phase(90, 4000);
      drain();
    end

    if (errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end
endmodule
